FILE: rtl/sfp_pkg.sv
package sfp_pkg;

   // one input item
   typedef struct packed {
      logic        action;
      logic [31:0] target_x;
      logic [31:0] target_y;
      logic [11:0] pointer_x;
      logic [11:0] pointer_y;
      logic [15:0] frame_time;
   } req_type;

   // one result item
   typedef struct packed {
      logic [31:0] view_x;
      logic [31:0] view_y;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [15:0] smoothness_rate;
      logic [15:0] pointer_gain;
      logic [15:0] max_pointer_offset;
   } cfg_type;

   // register indexes
   localparam logic [1:0] REG_SMOOTHNESS_RATE    = 2'd0;
   localparam logic [1:0] REG_POINTER_GAIN       = 2'd1;
   localparam logic [1:0] REG_MAX_POINTER_OFFSET = 2'd2;

   localparam logic [15:0] RST_SMOOTHNESS_RATE    = 16'd1280;
   localparam logic [15:0] RST_POINTER_GAIN       = 16'd8192;
   localparam logic [15:0] RST_MAX_POINTER_OFFSET = 16'd3200;

   localparam logic        ACT_UPDATE = 1'b0;
   localparam logic        ACT_SNAP   = 1'b1;

   // series divisors of the exp approximation as reciprocals, product >> 22
   // exact floor for t^3 below 2^20 (divide by 6) and t^4 below 2^16 (divide by 24)
   localparam logic [32:0] RECIP_THREE_FACT = 33'd699051;
   localparam logic [32:0] RECIP_FOUR_FACT  = 33'd174763;

   // control between sequencer and divider
   typedef struct packed {
      logic        start;
      logic [32:0] num;
      logic [17:0] den;
   } div_req_type;

endpackage

FILE: rtl/sfp_mul.sv
module sfp_mul (
   input  logic        clock,
   input  logic [32:0] mul_a,
   input  logic [32:0] mul_b,
   output logic [65:0] mul_p
);

   logic [65:0] prod_ff;
   logic [65:0] prod_in;

   // unsigned product, registered
   assign prod_in = 66'(mul_a) * 66'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

FILE: rtl/sfp_div.sv
module sfp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sfp_pkg::div_req_type div_req,
   output logic                 div_busy,
   output logic [32:0]          div_quo
);

   logic [17:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [17:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [18:0] trial;
   logic        fits;

   // one quotient bit a cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[32]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? 18'(trial - {1'b0, den_ff}) : trial[17:0];
         quo_in = {quo_ff[31:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_busy = busy_ff;
   assign div_quo  = quo_ff;

endmodule

FILE: rtl/sfp_seq.sv
module sfp_seq #(
   parameter int DISPLAY_WIDTH  = 1280,
   parameter int DISPLAY_HEIGHT = 720
) (
   input  logic             clock,
   input  logic             reset,
   input  sfp_pkg::cfg_type cfg,
   input  logic             start,
   input  sfp_pkg::req_type item,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output sfp_pkg::rsp_type result
);

   localparam logic [17:0] CENTER_X = 18'(DISPLAY_WIDTH * 8);
   localparam logic [17:0] CENTER_Y = 18'(DISPLAY_HEIGHT * 8);

   typedef enum logic [5:0] {
      ST_IDLE, ST_OFS, ST_SQX, ST_SQY, ST_SQS, ST_SQRT, ST_LIM,
      ST_DXM, ST_DXS, ST_DXW, ST_DYM, ST_DYS, ST_DYW,
      ST_GX, ST_GXW, ST_GYW, ST_FOFF,
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
      ST_SOX, ST_SOXW, ST_SOY, ST_SOYW, ST_PX,
      ST_SVX, ST_SVXW, ST_SVY, ST_SVYW, ST_FIN
   } state_type;

   state_type   st_ff, st_in;
   sfp_pkg::req_type in_ff, in_in;
   logic signed [17:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [33:0] sq_ff, sq_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [31:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [23:0] x_ff, x_in;
   logic [27:0] t_ff, t_in;
   logic [23:0] t2_ff, t2_in;
   logic [19:0] t3_ff, t3_in;
   logic [15:0] t4_ff, t4_in;
   logic [17:0] d3_ff, d3_in;
   logic [33:0] e_ff, e_in;
   logic [16:0] a_ff, a_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        fsel_ff, fsel_in;
   logic        neg_ff, neg_in;

   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   sfp_pkg::div_req_type div_req;
   logic        div_busy;
   logic [32:0] div_quo;

   logic [33:0] trial;
   logic signed [32:0] diff, goal;
   logic [32:0] dmag;
   logic [33:0] step;
   logic [33:0] e_sum;

   sfp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   sfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_quo  (div_quo)
   );

   // smoothing operands for whichever component is being worked
   always_comb begin
      goal = '0;
      diff = '0;
      case (st_ff)
         ST_SOX:  diff = 33'(signed'(gx_ff)) - 33'(signed'(offx_ff));
         ST_SOY:  diff = 33'(signed'(gy_ff)) - 33'(signed'(offy_ff));
         ST_SVX: begin
            goal = 33'(signed'(in_ff.target_x)) + 33'(signed'(offx_ff));
            if (goal > 33'sh0_7FFF_FFFF) goal = 33'sh0_7FFF_FFFF;
            if (goal < -33'sh0_8000_0000) goal = -33'sh0_8000_0000;
            diff = goal - 33'(signed'(vx_ff));
         end
         ST_SVY: begin
            goal = 33'(signed'(in_ff.target_y)) + 33'(signed'(offy_ff));
            if (goal > 33'sh0_7FFF_FFFF) goal = 33'sh0_7FFF_FFFF;
            if (goal < -33'sh0_8000_0000) goal = -33'sh0_8000_0000;
            diff = goal - 33'(signed'(vy_ff));
         end
         default: diff = '0;
      endcase
      dmag = diff[32] ? 33'(-diff) : 33'(diff);
   end

   // truncated-toward-zero step from the last product
   assign step = neg_ff ? 34'(-mul_p[49:16]) : mul_p[49:16];

   assign trial = res_ff + bit_ff;
   assign e_sum = 34'h1_0000_0000 - 34'(t_ff) + 34'(t2_ff[23:1]) - 34'(d3_ff)
                  + 34'(mul_p[37:22]);

   // sequencer
   always_comb begin
      st_in   = st_ff;
      in_in   = in_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      sq_in   = sq_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      gx_in   = gx_ff;
      gy_in   = gy_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      vx_in   = vx_ff;
      vy_in   = vy_ff;
      x_in    = x_ff;
      t_in    = t_ff;
      t2_in   = t2_ff;
      t3_in   = t3_ff;
      t4_in   = t4_ff;
      d3_in   = d3_ff;
      e_in    = e_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      fsel_in = fsel_ff;
      neg_in  = neg_ff;
      mul_a   = '0;
      mul_b   = '0;
      div_req = '0;
      done    = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               in_in = item;
               if (item.action == sfp_pkg::ACT_SNAP) begin
                  vx_in = item.target_x;
                  vy_in = item.target_y;
                  st_in = ST_FIN;
               end else begin
                  st_in = ST_OFS;
               end
            end
         end
         // pointer offset from the screen centre, Q.4
         ST_OFS: begin
            ox_in = signed'({2'b0, in_ff.pointer_x, 4'b0} - CENTER_X);
            oy_in = signed'({2'b0, in_ff.pointer_y, 4'b0} - CENTER_Y);
            st_in = ST_SQX;
         end
         ST_SQX: begin
            mul_a = 33'(ox_ff[17] ? -ox_ff : ox_ff);
            mul_b = mul_a;
            st_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in = mul_p[33:0];
            mul_a = 33'(oy_ff[17] ? -oy_ff : oy_ff);
            mul_b = mul_a;
            st_in = ST_SQS;
         end
         ST_SQS: begin
            sq_in  = sq_ff + mul_p[33:0];
            res_in = '0;
            bit_in = 34'h1_0000_0000;
            st_in  = ST_SQRT;
         end
         // integer square root, one result bit a cycle
         ST_SQRT: begin
            if (sq_ff >= trial) begin
               sq_in  = sq_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) st_in = ST_LIM;
         end
         ST_LIM: begin
            if (res_ff > 34'(cfg.max_pointer_offset)) st_in = ST_DXM;
            else st_in = ST_GX;
         end
         // clamp to the length limit: |o|*lim/len
         ST_DXM: begin
            mul_a = 33'(ox_ff[17] ? -ox_ff : ox_ff);
            mul_b = 33'(cfg.max_pointer_offset);
            st_in = ST_DXS;
         end
         ST_DXS: begin
            div_req.start = 1'b1;
            div_req.num   = mul_p[32:0];
            div_req.den   = res_ff[17:0];
            st_in = ST_DXW;
         end
         ST_DXW: begin
            if (!div_busy) begin
               ox_in = ox_ff[17] ? -signed'(div_quo[17:0]) : signed'(div_quo[17:0]);
               st_in = ST_DYM;
            end
         end
         ST_DYM: begin
            mul_a = 33'(oy_ff[17] ? -oy_ff : oy_ff);
            mul_b = 33'(cfg.max_pointer_offset);
            st_in = ST_DYS;
         end
         ST_DYS: begin
            div_req.start = 1'b1;
            div_req.num   = mul_p[32:0];
            div_req.den   = res_ff[17:0];
            st_in = ST_DYW;
         end
         ST_DYW: begin
            if (!div_busy) begin
               oy_in = oy_ff[17] ? -signed'(div_quo[17:0]) : signed'(div_quo[17:0]);
               st_in = ST_GX;
            end
         end
         // pointer gain to Q16.16
         ST_GX: begin
            mul_a = 33'(ox_ff[17] ? -ox_ff : ox_ff);
            mul_b = 33'(cfg.pointer_gain);
            st_in = ST_GXW;
         end
         ST_GXW: begin
            gx_in = ox_ff[17] ? 32'(-mul_p[34:3]) : mul_p[34:3];
            mul_a = 33'(oy_ff[17] ? -oy_ff : oy_ff);
            mul_b = 33'(cfg.pointer_gain);
            st_in = ST_GYW;
         end
         ST_GYW: begin
            gy_in = oy_ff[17] ? 32'(-mul_p[34:3]) : mul_p[34:3];
            st_in = ST_FOFF;
         end
         ST_FOFF: begin
            x_in    = 24'({in_ff.frame_time, 4'b0} - {4'b0, in_ff.frame_time});
            fsel_in = 1'b0;
            st_in   = ST_F0;
         end
         // factor 1-exp(-x): series for exp(-x/256), then eight squarings; 1.0 once x reaches 16
         ST_F0: begin
            if (|x_ff[23:20]) begin
               a_in  = 17'h1_0000;
               st_in = fsel_ff ? ST_SVX : ST_SOX;
            end else begin
               t_in  = {x_ff[19:0], 8'b0};
               mul_a = 33'({x_ff[19:0], 8'b0});
               mul_b = mul_a;
               st_in = ST_F1;
            end
         end
         ST_F1: begin
            t2_in = mul_p[55:32];
            mul_a = 33'(mul_p[55:32]);
            mul_b = 33'(t_ff);
            st_in = ST_F2;
         end
         ST_F2: begin
            t3_in = mul_p[51:32];
            mul_a = 33'(mul_p[51:32]);
            mul_b = 33'(t_ff);
            st_in = ST_F3;
         end
         // t^3/6 and t^4/24 by reciprocal multiplication
         ST_F3: begin
            t4_in = mul_p[47:32];
            mul_a = 33'(t3_ff);
            mul_b = sfp_pkg::RECIP_THREE_FACT;
            st_in = ST_F4;
         end
         ST_F4: begin
            d3_in = mul_p[39:22];
            mul_a = 33'(t4_ff);
            mul_b = sfp_pkg::RECIP_FOUR_FACT;
            st_in = ST_F5;
         end
         ST_F5: begin
            e_in   = e_sum[32] ? 34'h0_FFFF_FFFF : e_sum;
            cnt_in = 3'd0;
            st_in  = ST_F6;
         end
         ST_F6: begin
            mul_a = 33'(e_ff[31:0]);
            mul_b = 33'(e_ff[31:0]);
            st_in = ST_F7;
         end
         ST_F7: begin
            e_in   = 34'(mul_p[63:32]);
            cnt_in = cnt_ff + 3'd1;
            st_in  = (cnt_ff == 3'd7) ? ST_F8 : ST_F6;
         end
         ST_F8: begin
            a_in  = 17'((34'h1_0000_0000 - e_ff + 34'h8000) >> 16);
            st_in = fsel_ff ? ST_SVX : ST_SOX;
         end
         // smooth the pointer offset
         ST_SOX: begin
            neg_in = diff[32];
            mul_a  = dmag;
            mul_b  = 33'(a_ff);
            st_in  = ST_SOXW;
         end
         ST_SOXW: begin
            offx_in = offx_ff + step[31:0];
            st_in   = ST_SOY;
         end
         ST_SOY: begin
            neg_in = diff[32];
            mul_a  = dmag;
            mul_b  = 33'(a_ff);
            st_in  = ST_SOYW;
         end
         ST_SOYW: begin
            offy_in = offy_ff + step[31:0];
            mul_a   = 33'(cfg.smoothness_rate);
            mul_b   = 33'(in_ff.frame_time);
            st_in   = ST_PX;
         end
         ST_PX: begin
            x_in    = mul_p[31:8];
            fsel_in = 1'b1;
            st_in   = ST_F0;
         end
         // smooth the view toward target plus offset
         ST_SVX: begin
            neg_in = diff[32];
            mul_a  = dmag;
            mul_b  = 33'(a_ff);
            st_in  = ST_SVXW;
         end
         ST_SVXW: begin
            vx_in = vx_ff + step[31:0];
            st_in = ST_SVY;
         end
         ST_SVY: begin
            neg_in = diff[32];
            mul_a  = dmag;
            mul_b  = 33'(a_ff);
            st_in  = ST_SVYW;
         end
         ST_SVYW: begin
            vy_in = vy_ff + step[31:0];
            st_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               done  = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         offx_ff <= '0;
         offy_ff <= '0;
         vx_ff   <= '0;
         vy_ff   <= '0;
      end else begin
         st_ff   <= st_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
      end
      in_ff   <= in_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      sq_ff   <= sq_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      x_ff    <= x_in;
      t_ff    <= t_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      t4_ff   <= t4_in;
      d3_ff   <= d3_in;
      e_ff    <= e_in;
      a_ff    <= a_in;
      cnt_ff  <= cnt_in;
      fsel_ff <= fsel_in;
      neg_ff  <= neg_in;
   end

   assign idle          = (st_ff == ST_IDLE);
   assign result.view_x = vx_ff;
   assign result.view_y = vy_ff;

   // divider is never restarted while working
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_busy)
      else $error("divider started while busy");

   // an accepted item leaves idle on the next cycle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (idle && start) |=> !idle)
      else $error("item accepted but sequencer stayed idle");

   // completion returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> idle)
      else $error("completion without return to idle");

endmodule

FILE: rtl/smoothed_follow_position.sv
// View position follower: each item either snaps the view to the target or runs one
// smoothing step (pointer offset, length clamp, gain, two exponential smoothers). An update
// uses one shared registered multiplier, a square root, the length clamp (only when the
// pointer offset is longer than the limit: two quotients on the shared iterative divider)
// and two smoothing factors (series plus eight squarings), a factor going straight to 1.0
// when its exponent reaches 16. The input stalls while an item is being worked on; the
// result sits in an output register until taken, and a stalled result holds the sequencer.
module smoothed_follow_position #(
   parameter int DISPLAY_WIDTH  = 1280,
   parameter int DISPLAY_HEIGHT = 720
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfp_pkg::rsp_type rsp_item,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   sfp_pkg::cfg_type cfg_ff, cfg_in;
   sfp_pkg::rsp_type out_ff, out_in;
   logic             oval_ff, oval_in;
   logic             idle, done, out_free, wr;
   sfp_pkg::rsp_type result;

   sfp_seq #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (req_valid && idle),
      .item     (req_item),
      .out_free (out_free),
      .idle     (idle),
      .done     (done),
      .result   (result)
   );

   // configuration writes
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[3:2])
            sfp_pkg::REG_SMOOTHNESS_RATE:    cfg_in.smoothness_rate    = csr_pwdata[15:0];
            sfp_pkg::REG_POINTER_GAIN:       cfg_in.pointer_gain       = csr_pwdata[15:0];
            sfp_pkg::REG_MAX_POINTER_OFFSET: cfg_in.max_pointer_offset = csr_pwdata[15:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr[3:2])
         sfp_pkg::REG_SMOOTHNESS_RATE:    csr_prdata = 32'(cfg_ff.smoothness_rate);
         sfp_pkg::REG_POINTER_GAIN:       csr_prdata = 32'(cfg_ff.pointer_gain);
         sfp_pkg::REG_MAX_POINTER_OFFSET: csr_prdata = 32'(cfg_ff.max_pointer_offset);
         default:                         csr_prdata = '0;
      endcase
   end

   // output register
   assign out_free = !oval_ff || !rsp_stall;
   always_comb begin
      out_in  = out_ff;
      oval_in = oval_ff && rsp_stall;
      if (done) begin
         out_in  = result;
         oval_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothness_rate    <= sfp_pkg::RST_SMOOTHNESS_RATE;
         cfg_ff.pointer_gain       <= sfp_pkg::RST_POINTER_GAIN;
         cfg_ff.max_pointer_offset <= sfp_pkg::RST_MAX_POINTER_OFFSET;
         oval_ff                   <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         oval_ff <= oval_in;
      end
      out_ff <= out_in;
   end

   assign req_stall  = !idle;
   assign rsp_valid  = oval_ff;
   assign rsp_item   = out_ff;
   assign csr_pready = 1'b1;

endmodule

FILE: dv/smoothed_follow_position_test.sv
module smoothed_follow_position_test;

   localparam int SCREEN_W = 1280;
   localparam int SCREEN_H = 720;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sfp_pkg::req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sfp_pkg::rsp_type rsp_item;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   smoothed_follow_position dut (.*);

   always #10 clock = ~clock;

   // predictor state and register copies
   logic [15:0] rate_q, gain_q, limit_q;
   logic signed [31:0] pos_x, pos_y, off_x, off_y;
   sfp_pkg::rsp_type view_queue[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          take_idle_pct = 0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic longint isqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // truncate toward zero
   function automatic longint scale_shr(input longint v, input longint unsigned m,
                                        input int sh);
      longint unsigned mag;
      mag = v < 0 ? -v : v;
      mag = (mag * m) >> sh;
      return v < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   // 1 - exp(-x), Q16.16 in, Q1.16 out
   function automatic longint unsigned decay_factor(input longint unsigned x);
      longint unsigned t, t2, t3, t4, e;
      if (x >= (64'd16 << 16)) return 65536;
      t = x << 8;
      t2 = (t * t) >> 32;
      t3 = (t2 * t) >> 32;
      t4 = (t3 * t) >> 32;
      e = (64'd1 << 32) - t + t2 / 2 - t3 / 6 + t4 / 24;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      for (int i = 0; i < 8; i++) e = (e * e) >> 32;
      return ((64'd1 << 32) - e + (64'd1 << 15)) >> 16;
   endfunction

   function automatic logic signed [31:0] ease(input logic signed [31:0] s,
                                               input longint goal,
                                               input longint unsigned a);
      longint cur;
      cur = s;
      return 32'(cur + scale_shr(goal - cur, a, 16));
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic predict_view(input sfp_pkg::req_type it);
      longint ox, oy, gx, gy;
      longint unsigned len, a_off, a_pos;
      sfp_pkg::rsp_type r;
      if (it.action == sfp_pkg::ACT_SNAP) begin
         pos_x = it.target_x;
         pos_y = it.target_y;
      end else begin
         ox = longint'(it.pointer_x) * 16 - SCREEN_W * 8;
         oy = longint'(it.pointer_y) * 16 - SCREEN_H * 8;
         len = isqrt(ox * ox + oy * oy);
         if (len > limit_q) begin
            ox = (ox * longint'(limit_q)) / longint'(len);
            oy = (oy * longint'(limit_q)) / longint'(len);
         end
         gx = scale_shr(ox, gain_q, 3);
         gy = scale_shr(oy, gain_q, 3);
         a_off = decay_factor(15 * longint'(it.frame_time));
         off_x = ease(off_x, gx, a_off);
         off_y = ease(off_y, gy, a_off);
         a_pos = decay_factor((longint'(rate_q) * it.frame_time) >> 8);
         pos_x = ease(pos_x, clamp32(longint'($signed(it.target_x)) + off_x), a_pos);
         pos_y = ease(pos_y, clamp32(longint'($signed(it.target_y)) + off_y), a_pos);
      end
      r.view_x = pos_x;
      r.view_y = pos_y;
      view_queue.push_back(r);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      sfp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (view_queue.size() == 0) begin
               report("result with nothing expected");
            end else begin
               want = view_queue.pop_front();
               if (rsp_item.view_x !== want.view_x)
                  report($sformatf("view_x %h want %h", rsp_item.view_x, want.view_x));
               if (rsp_item.view_y !== want.view_y)
                  report($sformatf("view_y %h want %h", rsp_item.view_y, want.view_y));
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < take_idle_pct);
   end

   // watchdog on cycles without any accepted item, taken result or register access
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("smoothed_follow_position regression: fail");
         $finish;
      end
   end

   // valid stays up after acceptance until the next item or an idle cycle
   task automatic send_item(input sfp_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_view(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (view_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         sfp_pkg::REG_SMOOTHNESS_RATE: rate_q = val;
         sfp_pkg::REG_POINTER_GAIN: gain_q = val;
         default: limit_q = val;
      endcase
      @(posedge clock);
   endtask

   function automatic sfp_pkg::req_type rand_item(input int snap_pct);
      sfp_pkg::req_type it;
      it.action = ($urandom_range(99) < snap_pct) ? sfp_pkg::ACT_SNAP : sfp_pkg::ACT_UPDATE;
      it.target_x = $urandom;
      it.target_y = $urandom;
      if ($urandom_range(3) != 0) begin
         it.target_x = $signed(it.target_x) >>> 8;
         it.target_y = $signed(it.target_y) >>> 8;
      end
      it.pointer_x = 12'($urandom);
      it.pointer_y = 12'($urandom);
      case ($urandom_range(3))
         0: it.frame_time = 16'($urandom);
         1: it.frame_time = 16'($urandom_range(0, 16));
         default: it.frame_time = 16'($urandom_range(500, 3000));
      endcase
      return it;
   endfunction

   task automatic test_extremes();
      sfp_pkg::req_type it;
      it = '{sfp_pkg::ACT_SNAP, 32'h7FFF_FFFF, 32'h8000_0000, 12'd0, 12'd0, 16'd0};
      send_item(it);
      // goal saturation both ways
      it = '{sfp_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 12'hFFF, 12'd0, 16'hFFFF};
      send_item(it);
      it = '{sfp_pkg::ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 12'd0, 12'hFFF, 16'hFFFF};
      send_item(it);
      // zero frame time holds still
      it = '{sfp_pkg::ACT_UPDATE, 32'h0001_0000, 32'hFFFF_0000, 12'd640, 12'd360, 16'd0};
      send_item(it);
      it = '{sfp_pkg::ACT_UPDATE, 32'h0010_0000, 32'h0020_0000, 12'd640, 12'd360, 16'd1};
      send_item(it);
      it = '{sfp_pkg::ACT_UPDATE, 32'h0010_0000, 32'h0020_0000, 12'd1000, 12'd100, 16'd1092};
      send_item(it);
      it = '{sfp_pkg::ACT_SNAP, 32'hFFFF_FFFF, 32'h0, 12'hFFF, 12'hFFF, 16'hFFFF};
      send_item(it);
      drain();
   endtask

   task automatic test_registers();
      write_reg(sfp_pkg::REG_MAX_POINTER_OFFSET, 16'd0);
      write_reg(sfp_pkg::REG_POINTER_GAIN, 16'hFFFF);
      write_reg(sfp_pkg::REG_SMOOTHNESS_RATE, 16'hFFFF);
      for (int i = 0; i < 6; i++) send_item(rand_item(10));
      drain();
      write_reg(sfp_pkg::REG_MAX_POINTER_OFFSET, 16'hFFFF);
      write_reg(sfp_pkg::REG_POINTER_GAIN, 16'd0);
      write_reg(sfp_pkg::REG_SMOOTHNESS_RATE, 16'd0);
      for (int i = 0; i < 6; i++) send_item(rand_item(10));
      drain();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99) begin
            drain();
            write_reg(sfp_pkg::REG_SMOOTHNESS_RATE, 16'($urandom));
            write_reg(sfp_pkg::REG_POINTER_GAIN, 16'($urandom));
            write_reg(sfp_pkg::REG_MAX_POINTER_OFFSET,
                      ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 4000)));
         end
         send_item(rand_item(12));
      end
      drain();
   endtask

   initial begin
      rate_q = sfp_pkg::RST_SMOOTHNESS_RATE;
      gain_q = sfp_pkg::RST_POINTER_GAIN;
      limit_q = sfp_pkg::RST_MAX_POINTER_OFFSET;
      pos_x = 0; pos_y = 0; off_x = 0; off_y = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_registers();
      send_idle_pct = 37; take_idle_pct = 81;
      test_random(400);
      send_idle_pct = 81; take_idle_pct = 37;
      test_random(400);
      send_idle_pct = 0; take_idle_pct = 0;
      test_random(400);
      if (error_count == 0)
         $display("smoothed_follow_position regression: pass");
      else
         $display("smoothed_follow_position regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/sfp_pkg.sv
rtl/sfp_mul.sv
rtl/sfp_div.sv
rtl/sfp_seq.sv
rtl/smoothed_follow_position.sv
dv/smoothed_follow_position_test.sv
